>>> hw/rtl/mqd_pkg.sv
// Package for the min queue with monotonic deque.
// Holds the sequencer state type, request mode and status codes, and field widths.
// No dependencies.
`timescale 1ns / 1ps

package mqd_pkg;

   localparam int DataW   = 32;
   localparam int ModeW   = 2;
   localparam int StatusW = 2;
   localparam int CountW  = 11;

   typedef enum logic [ModeW-1:0] {
      MODE_ENQ   = 2'd0,
      MODE_DEQ   = 2'd1,
      MODE_CLR   = 2'd2,
      MODE_QUERY = 2'd3
   } mqd_mode_type;

   typedef enum logic [StatusW-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } mqd_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENQ_RD,
      ST_ENQ_CMP,
      ST_ENQ_APP,
      ST_DEQ_RD,
      ST_DEQ_LD,
      ST_DONE
   } mqd_state_type;

endpackage

>>> hw/rtl/mqd_ram.sv
// Simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mqd_ram #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/min_queue_monotonic_deque.sv
// Top level of the min queue: FIFO of signed values with a running minimum.
// Depends on mqd_pkg and instantiates two mqd_ram rings.
`timescale 1ns / 1ps

// A FIFO of signed 32-bit values that reports its minimum with every response.
// Each request carries a mode (enqueue, dequeue, clear, query) and a value for
// enqueue. Each request produces exactly one response with status, the value
// removed by a dequeue, the count, an empty flag, the front value and the
// minimum. The minimum comes from a second ring, a monotonic deque that holds
// non-decreasing candidates. The block takes one request at a time. Clear and
// query go straight to the response, and so do a dequeue on an empty queue and
// an enqueue on a full one. Any other dequeue first waits for the registered
// read that refills the cached front and minimum. An enqueue does one deque
// read and compare for each entry that it drops from the deque back, one more
// when an older entry stays, and none when the deque is empty; each compare
// needs a deque read through the registered memory port. Every value leaves
// the deque at most once, so over a long run there is on average at most one
// drop per enqueue. A finished response waits in an output register, so a
// stalled response does not stop the next request from being accepted. Memory
// contents are not cleared after reset; only written entries are ever read.
module min_queue_monotonic_deque
   import mqd_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [ModeW-1:0]          req_mode,
   input  logic signed [DataW-1:0]   req_push_value,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [StatusW-1:0]        rsp_status,
   output logic signed [DataW-1:0]   rsp_popped_value,
   output logic [CountW-1:0]         rsp_count,
   output logic                      rsp_is_empty,
   output logic signed [DataW-1:0]   rsp_front_value,
   output logic signed [DataW-1:0]   rsp_min_value
);

   // Ring index width and a count width that can hold DEPTH itself.
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DepthSum = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);

   // Reduce head plus offset, known to be below twice the depth, into the ring.
   function automatic logic [AW-1:0] wrap(input logic [AW:0] sum);
      logic [AW:0] red;
      red = (sum >= DepthSum) ? (sum - DepthSum) : sum;
      return red[AW-1:0];
   endfunction

   // Sequencer and ring control state.
   mqd_state_type state_ff, state_in;
   logic [AW-1:0] fifo_head_ff, fifo_head_in;
   logic [CW-1:0] fifo_count_ff, fifo_count_in;
   logic [AW-1:0] min_head_ff, min_head_in;
   logic [CW-1:0] min_count_ff, min_count_in;
   logic          drop_ff, drop_in;

   // Cached copies of the FIFO front and the deque front. They are only
   // meaningful while the matching ring holds something.
   logic signed [DataW-1:0] front_ff, front_in;
   logic signed [DataW-1:0] minf_ff, minf_in;

   // The request being worked on.
   logic signed [DataW-1:0] val_ff, val_in;
   logic [StatusW-1:0]      status_ff, status_in;
   logic signed [DataW-1:0] popped_ff, popped_in;

   // Response register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [StatusW-1:0]      rsp_status_ff, rsp_status_in;
   logic signed [DataW-1:0] rsp_popped_ff, rsp_popped_in;
   logic [CountW-1:0]       rsp_count_ff, rsp_count_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic signed [DataW-1:0] rsp_front_ff, rsp_front_in;
   logic signed [DataW-1:0] rsp_min_ff, rsp_min_in;

   // Memory ports.
   logic              fifo_we;
   logic [AW-1:0]     fifo_waddr;
   logic [AW-1:0]     fifo_raddr;
   logic [DataW-1:0]  fifo_rdata;
   logic              min_we;
   logic [AW-1:0]     min_waddr;
   logic [AW-1:0]     min_raddr;
   logic [DataW-1:0]  min_rdata;

   logic          req_accept;
   logic          rsp_slot_free;
   logic [AW-1:0] fifo_tail;
   logic [AW-1:0] min_tail;
   logic [AW-1:0] min_back;
   logic          back_greater;
   mqd_mode_type  mode;

   assign mode          = mqd_mode_type'(req_mode);
   assign req_stall     = (state_ff != ST_IDLE);
   assign req_accept    = req_valid && !req_stall;
   assign rsp_slot_free = !rsp_valid_ff || !rsp_stall;

   assign fifo_tail = wrap({1'b0, fifo_head_ff} + (AW + 1)'(fifo_count_ff));
   assign min_tail  = wrap({1'b0, min_head_ff} + (AW + 1)'(min_count_ff));
   assign min_back  = wrap({1'b0, min_head_ff} + (AW + 1)'(min_count_ff) - (AW + 1)'(1));

   // The one compare unit: deque back against the value being enqueued.
   assign back_greater = $signed(min_rdata) > val_ff;

   mqd_ram #(
      .DEPTH  (DEPTH),
      .DATA_W (DataW)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (fifo_waddr),
      .wr_data (req_push_value),
      .rd_addr (fifo_raddr),
      .rd_data (fifo_rdata)
   );

   mqd_ram #(
      .DEPTH  (DEPTH),
      .DATA_W (DataW)
   ) u_min_ram (
      .clock   (clock),
      .wr_en   (min_we),
      .wr_addr (min_waddr),
      .wr_data (val_ff),
      .rd_addr (min_raddr),
      .rd_data (min_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (mode)
                  MODE_ENQ: begin
                     if (fifo_count_ff == DepthCnt) begin
                        state_in = ST_DONE;
                     end else if (min_count_ff != '0) begin
                        state_in = ST_ENQ_RD;
                     end else begin
                        state_in = ST_ENQ_APP;
                     end
                  end
                  MODE_DEQ: begin
                     state_in = (fifo_count_ff == '0) ? ST_DONE : ST_DEQ_RD;
                  end
                  MODE_CLR, MODE_QUERY: begin
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_ENQ_RD: begin
            state_in = ST_ENQ_CMP;
         end
         ST_ENQ_CMP: begin
            if (back_greater && (min_count_ff != CW'(1))) begin
               state_in = ST_ENQ_RD;
            end else begin
               state_in = ST_ENQ_APP;
            end
         end
         ST_ENQ_APP: begin
            state_in = ST_DONE;
         end
         ST_DEQ_RD: begin
            state_in = ST_DEQ_LD;
         end
         ST_DEQ_LD: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      fifo_head_in  = fifo_head_ff;
      fifo_count_in = fifo_count_ff;
      min_head_in   = min_head_ff;
      min_count_in  = min_count_ff;
      drop_in       = drop_ff;
      front_in      = front_ff;
      minf_in       = minf_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      popped_in     = popped_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_min_in    = rsp_min_ff;

      fifo_we    = 1'b0;
      fifo_waddr = fifo_tail;
      fifo_raddr = fifo_head_ff;
      min_we     = 1'b0;
      min_waddr  = min_tail;
      min_raddr  = min_head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               status_in = STATUS_OK;
               popped_in = '0;
               val_in    = req_push_value;
               drop_in   = 1'b0;
               unique case (mode)
                  MODE_ENQ: begin
                     if (fifo_count_ff == DepthCnt) begin
                        status_in = STATUS_FULL;
                     end else begin
                        fifo_we       = 1'b1;
                        fifo_count_in = fifo_count_ff + CW'(1);
                        if (fifo_count_ff == '0) begin
                           front_in = req_push_value;
                        end
                     end
                  end
                  MODE_DEQ: begin
                     if (fifo_count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        popped_in     = front_ff;
                        fifo_head_in  = wrap({1'b0, fifo_head_ff} + (AW + 1)'(1));
                        fifo_count_in = fifo_count_ff - CW'(1);
                        // The minimum leaves with the value that equals it.
                        if ((min_count_ff != '0) && (minf_ff == front_ff)) begin
                           min_head_in  = wrap({1'b0, min_head_ff} + (AW + 1)'(1));
                           min_count_in = min_count_ff - CW'(1);
                           drop_in      = 1'b1;
                        end
                     end
                  end
                  MODE_CLR: begin
                     fifo_head_in  = '0;
                     fifo_count_in = '0;
                     min_head_in   = '0;
                     min_count_in  = '0;
                  end
                  MODE_QUERY: begin
                     status_in = STATUS_OK;
                  end
                  default: begin
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end
         ST_ENQ_RD: begin
            min_raddr = min_back;
         end
         ST_ENQ_CMP: begin
            // Entries equal to the new value stay in the deque.
            if (back_greater) begin
               min_count_in = min_count_ff - CW'(1);
            end
         end
         ST_ENQ_APP: begin
            if (min_count_ff < DepthCnt) begin
               min_we       = 1'b1;
               min_count_in = min_count_ff + CW'(1);
               if (min_count_ff == '0) begin
                  minf_in = val_ff;
               end
            end
         end
         ST_DEQ_RD: begin
            fifo_raddr = fifo_head_ff;
            min_raddr  = min_head_ff;
         end
         ST_DEQ_LD: begin
            front_in = $signed(fifo_rdata);
            if (drop_ff) begin
               minf_in = $signed(min_rdata);
            end
         end
         ST_DONE: begin
            if (rsp_slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_popped_in = popped_ff;
               rsp_count_in  = CountW'(fifo_count_ff);
               rsp_empty_in  = (fifo_count_ff == '0);
               rsp_front_in  = (fifo_count_ff == '0) ? '0 : front_ff;
               rsp_min_in    = ((fifo_count_ff == '0) || (min_count_ff == '0)) ? '0 : minf_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fifo_head_ff  <= '0;
         fifo_count_ff <= '0;
         min_head_ff   <= '0;
         min_count_ff  <= '0;
         drop_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fifo_head_ff  <= fifo_head_in;
         fifo_count_ff <= fifo_count_in;
         min_head_ff   <= min_head_in;
         min_count_ff  <= min_count_in;
         drop_ff       <= drop_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff      <= front_in;
      minf_ff       <= minf_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      popped_ff     <= popped_in;
      rsp_status_ff <= rsp_status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_min_ff    <= rsp_min_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_count        = rsp_count_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_front_value  = rsp_front_ff;
   assign rsp_min_value    = rsp_min_ff;

endmodule

>>> tb/min_queue_monotonic_deque_tb.sv
// Self-checking testbench for min_queue_monotonic_deque, the FIFO with a running minimum.
// Uses mqd_pkg for the field widths, request modes and status codes, and needs only the RTL.
`timescale 1ns / 1ps

// The bench keeps a shadow copy of the queue and of its monotonic deque in two
// SystemVerilog queues. Every accepted request is applied to the shadow copy at
// the clock edge where it is accepted, and the queue report that the block
// should send back is stored in order. A checker compares each accepted
// response with the oldest stored report, field by field.
//
// The tests run in turn from one initial block:
//   - directed requests on the extremes and on each special case,
//   - a fill to the full depth behind a long receiver hold-off, then refusals,
//   - a run of random requests in phases that grow, shrink or balance the
//     queue, with changing sender pace.
// The sender idles in bursts, and the receiver stalls on a pattern of its own.
module min_queue_monotonic_deque_tb;
   import mqd_pkg::*;

   localparam int DEPTH       = 1024;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_REQS = 150;

   typedef logic signed [DataW-1:0] word_type;

   // What the block should report for one request.
   typedef struct {
      mqd_status_type       status;
      word_type             popped;
      logic [CountW-1:0]    count;
      logic                 is_empty;
      word_type             front;
      word_type             minimum;
   } queue_report_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [ModeW-1:0]  req_mode = MODE_QUERY;
   word_type          req_push_value = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [StatusW-1:0] rsp_status;
   word_type          rsp_popped_value;
   logic [CountW-1:0] rsp_count;
   logic              rsp_is_empty;
   word_type          rsp_front_value;
   word_type          rsp_min_value;

   // Shadow copy of the queue contents and of the minimum candidates.
   word_type         shadow_fifo[$];
   word_type         shadow_deque[$];
   queue_report_type reports_due[$];

   int failures = 0;
   int results_checked = 0;
   int mode_count[4];
   int full_refusals = 0;
   int empty_errors = 0;
   int peak_count = 0;
   int cycle_count = 0;

   // Sender pacing: a burst of back-to-back requests, then a random gap.
   int max_burst = 1;
   int max_gap = 0;
   int burst_left = 0;

   // Receiver stall pattern and the long hold-off that a test may request.
   int hold_off_left = 0;
   int stall_pattern = 0;
   int pattern_left = 0;
   int pattern_phase = 0;

   min_queue_monotonic_deque #(
      .DEPTH(DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .rsp_count        (rsp_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_front_value  (rsp_front_value),
      .rsp_min_value    (rsp_min_value)
   );

   always #2 clock = ~clock;

   function automatic void note_failure(string what);
      failures++;
      if (failures <= 10) begin
         $display("ERROR: %s", what);
      end
   endfunction

   // Applies one request to the shadow queue and returns the report it causes.
   // Deque entries strictly greater than a new value are dropped from the back,
   // so equal values stay and leave the minimum one at a time.
   function automatic queue_report_type apply_request(mqd_mode_type mode, word_type value);
      queue_report_type rpt;
      rpt.status = STATUS_OK;
      rpt.popped = '0;
      mode_count[mode]++;
      case (mode)
         MODE_ENQ: begin
            if (shadow_fifo.size() >= DEPTH) begin
               rpt.status = STATUS_FULL;
               full_refusals++;
            end else begin
               shadow_fifo.push_back(value);
               while (shadow_deque.size() > 0 && shadow_deque[$] > value) begin
                  void'(shadow_deque.pop_back());
               end
               shadow_deque.push_back(value);
            end
         end
         MODE_DEQ: begin
            if (shadow_fifo.size() == 0) begin
               rpt.status = STATUS_EMPTY;
               empty_errors++;
            end else begin
               rpt.popped = shadow_fifo.pop_front();
               if (shadow_deque.size() > 0 && shadow_deque[0] == rpt.popped) begin
                  void'(shadow_deque.pop_front());
               end
            end
         end
         MODE_CLR: begin
            shadow_fifo.delete();
            shadow_deque.delete();
         end
         default: begin
         end
      endcase
      if (shadow_fifo.size() > peak_count) begin
         peak_count = shadow_fifo.size();
      end
      rpt.count    = CountW'(shadow_fifo.size());
      rpt.is_empty = (shadow_fifo.size() == 0);
      rpt.front    = (shadow_fifo.size() == 0) ? '0 : shadow_fifo[0];
      rpt.minimum  = (shadow_fifo.size() == 0 || shadow_deque.size() == 0) ? '0
                                                                           : shadow_deque[0];
      return rpt;
   endfunction

   // Mostly full-range values, with extremes and a narrow band that makes
   // duplicates of the minimum common.
   function automatic word_type pick_value();
      word_type v;
      case ($urandom_range(0, 9))
         0: v = 32'sh8000_0000;
         1: v = 32'sh7FFF_FFFF;
         2, 3, 4: v = $signed($urandom_range(0, 8)) - 4;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic set_sender_pace(input int burst, input int gap);
      max_burst = burst;
      max_gap = gap;
      burst_left = 0;
   endtask

   // Offers one request at a falling edge and holds it until it is accepted.
   // The report is predicted at the rising edge where the handshake completes.
   task automatic send_request(input mqd_mode_type mode, input word_type value);
      @(negedge clock);
      if (max_gap > 0 && burst_left == 0) begin
         req_valid <= 1'b0;
         req_mode <= ModeW'($urandom_range(0, 3));
         req_push_value <= $urandom;
         repeat ($urandom_range(1, max_gap)) @(negedge clock);
         burst_left = $urandom_range(1, max_burst);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_push_value <= value;
      do @(posedge clock); while (req_stall);
      reports_due.push_back(apply_request(mode, value));
   endtask

   // Stops offering requests until every predicted report has come back.
   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (reports_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Extremes of the value range, every mode and each special case: dequeue,
   // clear and query on an empty queue, duplicates of the minimum leaving one
   // at a time, and the minimum moving up as smaller values leave.
   task automatic test_directed();
      set_sender_pace(1, 0);
      send_request(MODE_QUERY, $urandom);
      send_request(MODE_DEQ, $urandom);
      send_request(MODE_CLR, $urandom);
      send_request(MODE_ENQ, 32'sd5);
      send_request(MODE_ENQ, 32'sh7FFF_FFFF);
      send_request(MODE_ENQ, 32'sh8000_0000);
      send_request(MODE_ENQ, 32'sd3);
      send_request(MODE_ENQ, -32'sd1);
      send_request(MODE_ENQ, -32'sd1);
      send_request(MODE_ENQ, 32'sd0);
      send_request(MODE_QUERY, $urandom);
      send_request(MODE_DEQ, $urandom);
      send_request(MODE_DEQ, $urandom);
      send_request(MODE_DEQ, $urandom);
      send_request(MODE_DEQ, $urandom);
      send_request(MODE_DEQ, $urandom);
      send_request(MODE_QUERY, $urandom);
      send_request(MODE_ENQ, 32'sh7FFF_FFFF);
      send_request(MODE_CLR, $urandom);
      send_request(MODE_QUERY, $urandom);
      send_request(MODE_DEQ, $urandom);
      send_request(MODE_ENQ, -32'sd1);
      send_request(MODE_DEQ, $urandom);
      send_request(MODE_DEQ, $urandom);
   endtask

   // Fills the queue to its depth while the receiver holds off, so the output
   // register fills and the block stalls its input. The values rise slowly so
   // the deque grows to one below the full depth, and the last one is the most
   // negative value, which empties the deque in one long enqueue. Further enqueues
   // are refused as full; a few dequeues and enqueues then wrap the FIFO ring.
   task automatic test_fill_and_refuse();
      wait_until_drained();
      set_sender_pace(1, 0);
      send_request(MODE_CLR, $urandom);
      hold_off_left = HOLD_CYCLES;
      for (int i = 0; i < DEPTH - 1; i++) begin
         send_request(MODE_ENQ, -32'sd700 + 2 * i + $signed($urandom_range(0, 2)));
      end
      send_request(MODE_ENQ, 32'sh8000_0000);
      send_request(MODE_ENQ, 32'sh8000_0000);
      send_request(MODE_ENQ, pick_value());
      send_request(MODE_QUERY, $urandom);
      set_sender_pace(4, 3);
      repeat (3) send_request(MODE_DEQ, $urandom);
      repeat (3) send_request(MODE_ENQ, pick_value());
      send_request(MODE_ENQ, pick_value());
      send_request(MODE_QUERY, $urandom);
      send_request(MODE_CLR, $urandom);
   endtask

   // Random requests in phases. Each phase picks how strongly enqueues win over
   // dequeues, so the queue both empties often and grows deep, and picks a
   // sender pace, sometimes with no idling at all. Now and then the sender
   // waits until every report is back before going on.
   task automatic test_random_mix();
      int phase_left;
      int enq_share;
      int roll;
      mqd_mode_type mode;
      phase_left = 0;
      enq_share = 50;
      for (int n = 0; n < RANDOM_REQS; n++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(40, 120);
            case ($urandom_range(0, 2))
               0: enq_share = 42;
               1: enq_share = 62;
               default: enq_share = 88;
            endcase
            if ($urandom_range(0, 3) == 0) begin
               set_sender_pace(1, 0);
            end else begin
               set_sender_pace($urandom_range(1, 24), $urandom_range(1, 8));
            end
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            mode = MODE_CLR;
         end else if (roll < 12) begin
            mode = MODE_QUERY;
         end else if (roll < enq_share) begin
            mode = MODE_ENQ;
         end else begin
            mode = MODE_DEQ;
         end
         send_request(mode, mode == MODE_ENQ ? pick_value() : word_type'($urandom));
         if ($urandom_range(0, 99) == 0) begin
            wait_until_drained();
         end
      end
   endtask

   // Receiver: a long hold-off when a test asks for one, otherwise a stall
   // pattern that is picked anew at random from time to time (none, light, heavy,
   // periodic).
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            stall_pattern = $urandom_range(0, 3);
            pattern_left = $urandom_range(32, 256);
         end
         pattern_left--;
         pattern_phase++;
         case (stall_pattern)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= pattern_phase[2];
         endcase
      end
   end

   // Checker: each accepted response against the oldest predicted report.
   always @(posedge clock) begin
      queue_report_type exp_rpt;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reports_due.size() == 0) begin
            note_failure($sformatf("response with no request outstanding: status %0d count %0d",
                                   rsp_status, rsp_count));
         end else begin
            exp_rpt = reports_due.pop_front();
            results_checked++;
            if (rsp_status !== exp_rpt.status || rsp_popped_value !== exp_rpt.popped ||
                rsp_count !== exp_rpt.count || rsp_is_empty !== exp_rpt.is_empty ||
                rsp_front_value !== exp_rpt.front || rsp_min_value !== exp_rpt.minimum) begin
               note_failure($sformatf({"response %0d: expected status %0d popped %0d count %0d",
                                       " empty %0d front %0d min %0d, got status %0d",
                                       " popped %0d count %0d empty %0d front %0d min %0d"},
                                      results_checked, exp_rpt.status, exp_rpt.popped,
                                      exp_rpt.count, exp_rpt.is_empty, exp_rpt.front,
                                      exp_rpt.minimum, rsp_status, rsp_popped_value,
                                      rsp_count, rsp_is_empty, rsp_front_value,
                                      rsp_min_value));
            end
         end
      end
   end

   // Watchdog: far beyond the slowest correct run, including the long enqueue
   // that empties a full deque and the receiver hold-off.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ERROR: timeout with %0d responses still outstanding", reports_due.size());
         $display("min_queue_monotonic_deque: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_and_refuse();
      test_random_mix();
      wait_until_drained();
      // Every request has one response, so nothing is in flight by now; the extra
      // wait below catches any stray response.
      repeat (16) @(posedge clock);
      $display("Ran %0d enqueue, %0d dequeue, %0d clear and %0d query requests; %0d checked.",
               mode_count[MODE_ENQ], mode_count[MODE_DEQ], mode_count[MODE_CLR],
               mode_count[MODE_QUERY], results_checked);
      $display("Queue reached %0d entries; %0d full refusals, %0d empty dequeues, %0d errors.",
               peak_count, full_refusals, empty_errors, failures);
      if (failures == 0) begin
         $display("min_queue_monotonic_deque: match");
      end else begin
         $display("min_queue_monotonic_deque: mismatch");
      end
      $finish;
   end

endmodule
